// ===== src/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked at every rising edge outside reset.
`define SLPG_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define SLPG_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`else

`define SLPG_ASSERT(lbl, ck, rs, prop, msg)
`define SLPG_ASSERT_ALWAYS(lbl, ck, prop, msg)

`endif

`endif

// ===== src/slpg_pkg.sv =====
package slpg_pkg;

  // Number of axes per segment.
  localparam int NUM_AXES = 3;

  // Shared divider widths.
  localparam int DVD_W = 65;
  localparam int DVS_W = 32;

  // Item kinds carried in tuser.
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_SEG   = 2'd1;
  localparam logic [1:0] ACT_POINT = 2'd2;

  // Register indexes.
  localparam logic [2:0] REG_TIME_STEP = 3'd0;
  localparam logic [2:0] REG_DURATION  = 3'd1;
  localparam logic [2:0] REG_LOOP      = 3'd2;
  localparam logic [2:0] REG_DIGITS    = 3'd3;
  localparam logic [2:0] REG_SEG_COUNT = 3'd4;

  // Register reset values.
  localparam logic [19:0] RST_TIME_STEP = 20'd20000;
  localparam logic [31:0] RST_DURATION  = 32'd30000000;
  localparam logic [2:0]  RST_DIGITS    = 3'd6;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
    logic [DVS_W-1:0] remainder;
  } div_rsp_t;

  // Decimal scale for the rounding digits; codes above six act as six.
  function automatic logic [19:0] pow10(input logic [2:0] dg);
    logic [19:0] f;
    case (dg)
      3'd0: f = 20'd1;
      3'd1: f = 20'd10;
      3'd2: f = 20'd100;
      3'd3: f = 20'd1000;
      3'd4: f = 20'd10000;
      3'd5: f = 20'd100000;
      default: f = 20'd1000000;
    endcase
    return f;
  endfunction

endpackage

// ===== src/slpg_ram.sv =====
module slpg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/slpg_div.sv =====
module slpg_div (
  input  logic                clk,
  input  logic                rst,
  input  slpg_pkg::div_req_t  req,
  output slpg_pkg::div_rsp_t  rsp
);
  import slpg_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [DVS_W:0]   trial;
  logic             fits;
  logic [DVS_W:0]   diff;

  // One quotient bit per cycle, restoring form.
  always_comb begin
    trial = {rem, quo[DVD_W-1]};
    fits  = trial >= {1'b0, dvs};
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        quo  <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
        cnt  <= CNT_W'(DVD_W);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        quo <= {quo[DVD_W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

// ===== src/segmented_linear_profile_generator.sv =====
// Channel  Direction  Contents
// s_*      in         one item: tick, segment bounds or breakpoint (kind in s_tuser)
// m_*      out        one sample per tick: three accelerations, segment, time
// APB      in/out     configuration registers at byte addresses 0, 4, 8, 12, 16
//
// Load items are written to memory as they are accepted. A tick searches the segments
// one by one, then for each axis reads the profile length and breakpoints, interpolates
// between two points and rounds to the set decimal digits; interpolation and rounding
// both use the shared 65-step divider.
// After reset a clearing pass zeroes the profile lengths; no item is taken during it.
// A waiting sample does not block load items.
`include "assert_macros.svh"

module segmented_linear_profile_generator #(
  parameter int MAX_SEGMENTS = 16,
  parameter int MAX_POINTS   = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // segment_index[3:0], axis[5:4], point_index[9:6], time_value[41:10],
  // seg_end[73:42], accel_value[105:74], zero fill
  input  logic [111:0]  s_tdata,
  // action[1:0]
  input  logic [1:0]    s_tuser,
  input  logic          s_tlast,
  output logic          m_tvalid,
  input  logic          m_tready,
  // accel_x[31:0], accel_y[63:32], accel_z[95:64], segment_number[100:96],
  // segment_total[105:101], timestamp[137:106], zero fill
  output logic [143:0]  m_tdata,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import slpg_pkg::*;

  localparam int NUM_PROF = MAX_SEGMENTS * NUM_AXES;
  localparam int NUM_BP   = NUM_PROF * MAX_POINTS;
  localparam int SEG_AW   = MAX_SEGMENTS > 1 ? $clog2(MAX_SEGMENTS) : 1;
  localparam int PROF_AW  = $clog2(NUM_PROF);
  localparam int BP_AW    = $clog2(NUM_BP);
  localparam int PT_AW    = $clog2(MAX_POINTS);

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_SEG_RD, ST_SEG_CMP, ST_LEN_RD, ST_LEN_CHK,
    ST_P0_RD, ST_P0_CHK, ST_PL_RD, ST_PL_CHK, ST_PN_RD, ST_PN_CHK,
    ST_MUL, ST_IGO, ST_IWAIT, ST_RMUL, ST_RGO, ST_RWAIT, ST_OUT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [19:0] time_step;
  logic [31:0] total_duration;
  logic        loop_enable;
  logic [2:0]  rounding_digits;
  logic [4:0]  segment_count;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  // Input fields.
  logic [3:0]  in_seg;
  logic [1:0]  in_axis;
  logic [3:0]  in_pt;
  logic [31:0] in_time;
  logic [31:0] in_end;
  logic [31:0] in_accel;
  logic        accept;

  // Tick state.
  logic [31:0]        cur_time;
  logic [31:0]        t_smp;
  logic [31:0]        t_now;
  logic [32:0]        t_sum;
  logic [4:0]         count_r;
  logic [4:0]         cnt_clamp;
  logic [SEG_AW-1:0]  seg_idx;
  logic [31:0]        x_rel;
  logic [1:0]         axis_r;
  logic [4:0]         n_r;
  logic [4:0]         n_clamp;
  logic [PT_AW-1:0]   bp_idx;
  logic [31:0]        ti;
  logic [31:0]        tj;
  logic signed [31:0] vi;
  logic signed [31:0] vj;
  logic signed [31:0] vl;
  logic signed [31:0] val;
  logic               neg_r;
  logic               rneg;
  logic [63:0]        prod;
  logic [31:0]        den;
  logic [51:0]        rprod;
  logic signed [31:0] acc [NUM_AXES];
  logic [4:0]         number;
  logic [PROF_AW-1:0] clr_idx;

  // Datapath helpers.
  logic [32:0] dd;
  logic [31:0] mag;
  logic [31:0] magv;
  logic [19:0] f20;
  logic [36:0] rr;
  logic        irnd;
  logic [33:0] q1;
  logic [33:0] vext;
  logic [33:0] isum;
  logic        rrnd;
  logic [52:0] back;
  logic [31:0] rres;

  // Memory ports.
  logic               seg_we;
  logic [SEG_AW-1:0]  seg_waddr;
  logic [63:0]        seg_rdata;
  logic               len_we;
  logic [PROF_AW-1:0] len_waddr;
  logic [4:0]         len_wdata;
  logic [4:0]         len_rdata;
  logic [PROF_AW-1:0] prof_w;
  logic [PROF_AW-1:0] prof_r;
  logic               bp_we;
  logic [BP_AW-1:0]   bp_waddr;
  logic [BP_AW-1:0]   bp_raddr;
  logic [63:0]        bp_rdata;
  logic [31:0]        bt;
  logic signed [31:0] bv;
  logic [31:0]        s_start;
  logic [31:0]        s_end;
  logic               pt_ok;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // Unpack the input item.
  assign in_seg   = s_tdata[3:0];
  assign in_axis  = s_tdata[5:4];
  assign in_pt    = s_tdata[9:6];
  assign in_time  = s_tdata[41:10];
  assign in_end   = s_tdata[73:42];
  assign in_accel = s_tdata[105:74];
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step       <= RST_TIME_STEP;
      total_duration  <= RST_DURATION;
      loop_enable     <= 1'b0;
      rounding_digits <= RST_DIGITS;
      segment_count   <= 5'd0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TIME_STEP: time_step       <= pwdata[19:0];
        REG_DURATION:  total_duration  <= pwdata;
        REG_LOOP:      loop_enable     <= pwdata[0];
        REG_DIGITS:    rounding_digits <= pwdata[2:0];
        REG_SEG_COUNT: segment_count   <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_TIME_STEP: prdata = {12'd0, time_step};
      REG_DURATION:  prdata = total_duration;
      REG_LOOP:      prdata = {31'd0, loop_enable};
      REG_DIGITS:    prdata = {29'd0, rounding_digits};
      REG_SEG_COUNT: prdata = {27'd0, segment_count};
      default:       prdata = 32'd0;
    endcase
  end

  // Memory writes from load items, and the length clearing pass.
  assign pt_ok     = (int'(in_seg) < MAX_SEGMENTS) && (in_axis != 2'd3) &&
                     (int'(in_pt) < MAX_POINTS);
  assign prof_w    = PROF_AW'(in_seg) * PROF_AW'(NUM_AXES) + PROF_AW'(in_axis);
  assign seg_we    = accept && (s_tuser == ACT_SEG) && (int'(in_seg) < MAX_SEGMENTS);
  assign seg_waddr = SEG_AW'(in_seg);
  assign bp_we     = accept && (s_tuser == ACT_POINT) && pt_ok;
  assign bp_waddr  = BP_AW'(prof_w) * BP_AW'(MAX_POINTS) + BP_AW'(in_pt);
  assign len_we    = (state == ST_CLEAR) || (bp_we && s_tlast);
  assign len_waddr = (state == ST_CLEAR) ? clr_idx : prof_w;
  assign len_wdata = (state == ST_CLEAR) ? 5'd0 : 5'(in_pt) + 5'd1;

  // Read addresses follow the walk registers.
  assign prof_r   = PROF_AW'(seg_idx) * PROF_AW'(NUM_AXES) + PROF_AW'(axis_r);
  assign bp_raddr = BP_AW'(prof_r) * BP_AW'(MAX_POINTS) + BP_AW'(bp_idx);

  slpg_ram #(.WIDTH(64), .DEPTH(MAX_SEGMENTS)) u_seg_ram (
    .clk   (clk),
    .we    (seg_we),
    .waddr (seg_waddr),
    .wdata ({in_end, in_time}),
    .raddr (seg_idx),
    .rdata (seg_rdata)
  );

  slpg_ram #(.WIDTH(5), .DEPTH(NUM_PROF)) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (len_waddr),
    .wdata (len_wdata),
    .raddr (prof_r),
    .rdata (len_rdata)
  );

  slpg_ram #(.WIDTH(64), .DEPTH(NUM_BP)) u_bp_ram (
    .clk   (clk),
    .we    (bp_we),
    .waddr (bp_waddr),
    .wdata ({in_accel, in_time}),
    .raddr (bp_raddr),
    .rdata (bp_rdata)
  );

  slpg_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Arithmetic around the memories and the divider.
  always_comb begin
    t_now     = (loop_enable && (cur_time >= total_duration)) ? 32'd0 : cur_time;
    t_sum     = {1'b0, t_now} + 33'(time_step);
    cnt_clamp = (int'(segment_count) > MAX_SEGMENTS) ? 5'(MAX_SEGMENTS) : segment_count;
    n_clamp   = (int'(len_rdata) > MAX_POINTS) ? 5'(MAX_POINTS) : len_rdata;
    s_start   = seg_rdata[31:0];
    s_end     = seg_rdata[63:32];
    bt        = bp_rdata[31:0];
    bv        = bp_rdata[63:32];
    dd        = {vj[31], vj} - {vi[31], vi};
    mag       = dd[32] ? 32'(-dd) : dd[31:0];
    magv      = val[31] ? 32'(-val) : val;
    f20       = pow10(rounding_digits);
    rr        = 37'(rprod[51:16]) + 37'(rprod[15]);
    // Interpolation: round to nearest, ties away from the left value.
    irnd      = div_rsp.remainder >= (den - div_rsp.remainder);
    q1        = div_rsp.quotient[33:0] + 34'(irnd);
    vext      = {{2{vi[31]}}, vi};
    isum      = neg_r ? vext - q1 : vext + q1;
    // Decimal rounding back to Q16.16 with saturation.
    rrnd      = div_rsp.remainder >= (32'(f20) - div_rsp.remainder);
    back      = div_rsp.quotient[52:0] + 53'(rrnd);
    if (rneg) begin
      rres = (back > 53'h80000000) ? 32'h80000000 : 32'(-back);
    end else begin
      rres = (back > 53'h7FFFFFFF) ? 32'h7FFFFFFF : back[31:0];
    end
    div_req.start    = (state == ST_IGO) || (state == ST_RGO);
    div_req.dividend = (state == ST_RGO) ? DVD_W'({rr, 16'd0}) : DVD_W'(prod);
    div_req.divisor  = (state == ST_RGO) ? 32'(f20) : den;
  end

  // Tick sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_idx  <= '0;
      cur_time <= 32'd0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != ST_OUT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (int'(clr_idx) == NUM_PROF - 1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept && (s_tuser == ACT_TICK)) begin
            t_smp    <= t_now;
            cur_time <= t_sum[32] ? 32'hFFFFFFFF : t_sum[31:0];
            count_r  <= cnt_clamp;
            seg_idx  <= '0;
            number   <= 5'd1;
            for (int a = 0; a < NUM_AXES; a++) begin
              acc[a] <= 32'sd0;
            end
            state <= (cnt_clamp == 5'd0) ? ST_OUT : ST_SEG_RD;
          end
        end
        ST_SEG_RD: state <= ST_SEG_CMP;
        ST_SEG_CMP: begin
          if ((t_smp >= s_start) && (t_smp < s_end)) begin
            x_rel  <= t_smp - s_start;
            number <= 5'(seg_idx) + 5'd1;
            axis_r <= 2'd0;
            state  <= ST_LEN_RD;
          end else if (int'(seg_idx) + 1 == int'(count_r)) begin
            state <= ST_OUT;
          end else begin
            seg_idx <= seg_idx + 1'b1;
            state   <= ST_SEG_RD;
          end
        end
        ST_LEN_RD: state <= ST_LEN_CHK;
        ST_LEN_CHK: begin
          n_r <= n_clamp;
          if (n_clamp == 5'd0) begin
            val   <= 32'sd0;
            state <= ST_RMUL;
          end else begin
            bp_idx <= '0;
            state  <= ST_P0_RD;
          end
        end
        ST_P0_RD: state <= ST_P0_CHK;
        ST_P0_CHK: begin
          ti <= bt;
          vi <= bv;
          if ((n_r == 5'd1) || (x_rel <= bt)) begin
            val   <= bv;
            state <= ST_RMUL;
          end else begin
            bp_idx <= PT_AW'(n_r - 5'd1);
            state  <= ST_PL_RD;
          end
        end
        ST_PL_RD: state <= ST_PL_CHK;
        ST_PL_CHK: begin
          vl <= bv;
          if (x_rel >= bt) begin
            val   <= bv;
            state <= ST_RMUL;
          end else begin
            bp_idx <= PT_AW'(1);
            state  <= ST_PN_RD;
          end
        end
        ST_PN_RD: state <= ST_PN_CHK;
        ST_PN_CHK: begin
          if ((x_rel >= ti) && (x_rel <= bt)) begin
            if (ti == bt) begin
              val   <= vi;
              state <= ST_RMUL;
            end else begin
              tj    <= bt;
              vj    <= bv;
              state <= ST_MUL;
            end
          end else if (int'(bp_idx) + 1 == int'(n_r)) begin
            val   <= vl;
            state <= ST_RMUL;
          end else begin
            ti     <= bt;
            vi     <= bv;
            bp_idx <= bp_idx + 1'b1;
            state  <= ST_PN_RD;
          end
        end
        ST_MUL: begin
          neg_r <= dd[32];
          prod  <= 64'(mag) * 64'(x_rel - ti);
          den   <= tj - ti;
          state <= ST_IGO;
        end
        ST_IGO: state <= ST_IWAIT;
        ST_IWAIT: begin
          if (div_rsp.done) begin
            val   <= isum[31:0];
            state <= ST_RMUL;
          end
        end
        ST_RMUL: begin
          rneg  <= val[31];
          rprod <= 52'(magv) * 52'(f20);
          state <= ST_RGO;
        end
        ST_RGO: state <= ST_RWAIT;
        ST_RWAIT: begin
          if (div_rsp.done) begin
            acc[axis_r] <= rres;
            if (axis_r == 2'(NUM_AXES - 1)) begin
              state <= ST_OUT;
            end else begin
              axis_r <= axis_r + 2'd1;
              state  <= ST_LEN_RD;
            end
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'd0, t_smp, count_r, number, acc[2], acc[1], acc[0]};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `SLPG_ASSERT(a_tick_busy, clk, rst, (s_tvalid && s_tready && s_tuser == ACT_TICK) |=> !s_tready, "tick accepted but block still ready")
  `SLPG_ASSERT(a_div_wait, clk, rst, div_rsp.done |-> (state == ST_IWAIT || state == ST_RWAIT), "divider result with no consumer")
  `SLPG_ASSERT(a_scan_bound, clk, rst, (state == ST_PN_CHK) |-> (int'(bp_idx) < int'(n_r)), "breakpoint scan past profile end")
  `SLPG_ASSERT(a_time_adv, clk, rst, (s_tvalid && s_tready && s_tuser == ACT_TICK) |=> (cur_time >= t_smp), "time advance wrapped")
  `SLPG_ASSERT_ALWAYS(a_reset_clear, clk, rst |=> (state == ST_CLEAR), "reset did not start clearing pass")

endmodule
